### rtl/stiq_pkg.sv
`timescale 1ns / 1ps
package stiq_pkg;
   localparam int MAX_CHANNELS_DEF = 4;
   localparam int MAX_OUTPUTS_DEF = 64;
   localparam int ANGLE_BITS_DEF = 16;
   localparam int NUM_IN_FIELDS = 4;
   localparam int CORDIC_STEPS = 30;
   localparam logic [31:0] CORDIC_X0 = 32'h26DD3B6A;

   localparam logic [1:0] REG_FORMAT = 2'd0;
   localparam logic [1:0] REG_CHANNELS = 2'd1;
   localparam logic [1:0] REG_STEP = 2'd2;
   localparam logic [1:0] REG_GAIN = 2'd3;

   localparam logic [1:0] FMT_S8 = 2'd2;
   localparam logic [1:0] FMT_U8 = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_MUL, ST_ANGLE, ST_ROT, ST_EMIT
   } state_type;

   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      logic [31:0] t;
      case (i)
         5'd0: t = 32'h20000000;  5'd1: t = 32'h12E4051E;
         5'd2: t = 32'h09FB385B;  5'd3: t = 32'h051111D4;
         5'd4: t = 32'h028B0D43;  5'd5: t = 32'h0145D7E1;
         5'd6: t = 32'h00A2F61E;  5'd7: t = 32'h00517C55;
         5'd8: t = 32'h0028BE53;  5'd9: t = 32'h00145F2F;
         5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
         5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3;
         5'd14: t = 32'h0000A2FA; 5'd15: t = 32'h0000517D;
         5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
         5'd18: t = 32'h00000A30; 5'd19: t = 32'h00000518;
         5'd20: t = 32'h0000028C; 5'd21: t = 32'h00000146;
         5'd22: t = 32'h000000A3; 5'd23: t = 32'h00000051;
         5'd24: t = 32'h00000029; 5'd25: t = 32'h00000014;
         5'd26: t = 32'h0000000A; 5'd27: t = 32'h00000005;
         5'd28: t = 32'h00000003; 5'd29: t = 32'h00000001;
         5'd30: t = 32'h00000001;
         default: t = 32'h0;
      endcase
      return t;
   endfunction
endpackage

### rtl/stiq_cordic.sv
`timescale 1ns / 1ps
// Iterative rotation: one micro-rotation a cycle on a shared add/shift datapath.
module stiq_cordic #(
   parameter int ANGLE_BITS = stiq_pkg::ANGLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [ANGLE_BITS-1:0] angle,
   output logic                  done,
   output logic signed [11:0]    i_val,
   output logic signed [11:0]    q_val
);
   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [1:0] quad_ff, quad_in;
   logic [4:0] step_ff, step_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [31:0] a32, r32;
   logic [1:0] quad;
   logic signed [33:0] dx, dy, at, c, s, ns;

   always_comb begin
      a32 = {angle, {(32-ANGLE_BITS){1'b0}}};
      quad = 2'((a32 + 32'h20000000) >> 30);
      r32 = a32 - {quad, 30'd0};
      dx = y_ff >>> step_ff;
      dy = x_ff >>> step_ff;
      at = {2'b00, stiq_pkg::atan_turn(step_ff)};
      x_in = x_ff; y_in = y_ff; z_in = z_ff; quad_in = quad_ff;
      step_in = step_ff; busy_in = busy_ff;
      // flag the result in the same cycle that the last micro-rotation lands in the registers
      done_in = busy_ff && !start && (step_ff == 5'(stiq_pkg::CORDIC_STEPS - 1));
      if (start) begin
         x_in = {2'b00, stiq_pkg::CORDIC_X0};
         y_in = '0;
         z_in = {{2{r32[31]}}, r32};
         quad_in = quad;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_in = x_ff - dx; y_in = y_ff + dy; z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx; y_in = y_ff - dy; z_in = z_ff + at;
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'(stiq_pkg::CORDIC_STEPS - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         done_ff <= done_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; quad_ff <= quad_in;
   end

   function automatic logic signed [11:0] tr20(input logic signed [33:0] v);
      logic signed [33:0] m;
      m = v[33] ? -v : v;
      m = m >>> 20;
      return v[33] ? 12'(-m) : 12'(m);
   endfunction

   always_comb begin
      case (quad_ff)
         2'd0: begin c = x_ff; s = y_ff; end
         2'd1: begin c = -y_ff; s = x_ff; end
         2'd2: begin c = -x_ff; s = -y_ff; end
         default: begin c = y_ff; s = -x_ff; end
      endcase
      ns = -s;
      i_val = tr20(c);
      q_val = tr20(ns);
   end

   assign done = done_ff;
endmodule

### rtl/sample_to_iq_phase_modulator.sv
`timescale 1ns / 1ps
// An accepted beat first has its frame averaged, then each output point in turn passes
// multiply, angle, CORDIC start, 30 rotation steps, capture and a result beat.
// A frame yields 1 to 64 points; a result beat still waiting when the next point is
// ready holds the rotation. Not ready while a frame is worked.
// Synchronous reset restores register defaults, previous sample and position to zero.
module sample_to_iq_phase_modulator #(
   parameter int MAX_CHANNELS = stiq_pkg::MAX_CHANNELS_DEF,
   parameter int MAX_OUTPUTS_PER_INPUT = stiq_pkg::MAX_OUTPUTS_DEF,
   parameter int ANGLE_BITS = stiq_pkg::ANGLE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_chan0_raw,
   input  logic [15:0]        req_chan1_raw,
   input  logic [15:0]        req_chan2_raw,
   input  logic [15:0]        req_chan3_raw,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [11:0] rsp_i_out,
   output logic signed [11:0] rsp_q_out,
   output logic               rsp_last
);
   localparam int NLIM = (MAX_CHANNELS < stiq_pkg::NUM_IN_FIELDS) ?
                         MAX_CHANNELS : stiq_pkg::NUM_IN_FIELDS;
   localparam int MIN_STEP = (65536 + MAX_OUTPUTS_PER_INPUT - 1) / MAX_OUTPUTS_PER_INPUT;
   localparam int NUM = stiq_pkg::NUM_IN_FIELDS;

   stiq_pkg::state_type state_ff, state_in;
   logic [1:0] fmt_ff, fmt_in;
   logic [2:0] nch_ff, nch_in;
   logic [16:0] step_ff, step_in, pos_ff, pos_in;
   logic [15:0] gain_ff, gain_in;
   logic signed [15:0] prev_ff, prev_in, cur_ff, cur_in;
   logic signed [18:0] rem_ff, rem_in;
   logic [15:0] ch_ff [NUM];
   logic [31:0] v_ff, v_in;
   logic [31:0] prod_ff, prod_in;
   logic signed [11:0] iout_ff, iout_in, qout_ff, qout_in;
   logic last_ff, last_in, rv_ff, rv_in, cstart;
   logic [2:0] n_eff;
   logic [16:0] step_eff;
   logic signed [17:0] sum;
   logic signed [17:0] cv [NUM];
   logic signed [18:0] asum;
   logic [15:0] qabs;
   logic [17:0] pos_next;
   logic cdone;
   logic signed [11:0] ci, cq;

   function automatic logic signed [17:0] chval(input logic [1:0] f, input logic [15:0] w);
      logic [7:0] b;
      b = w[7:0];
      case (f)
         stiq_pkg::FMT_S8: return 18'(signed'(b));
         stiq_pkg::FMT_U8: return 18'(signed'({1'b0, b})) - 18'sd128;
         default: return 18'(signed'(w));
      endcase
   endfunction

   always_comb begin
      n_eff = (nch_ff == 3'd0) ? 3'd1 : ((32'(nch_ff) > NLIM) ? 3'(NLIM) : nch_ff);
      step_eff = (step_ff < 17'(MIN_STEP)) ? 17'(MIN_STEP) :
                 ((step_ff > 17'd65536) ? 17'd65536 : step_ff);
      sum = '0;
      for (int k = 0; k < NUM; k++) begin
         cv[k] = chval(fmt_ff, ch_ff[k]);
         if (k < 32'(n_eff)) sum = sum + cv[k];
      end
      asum = sum[17] ? -19'(sum) : 19'(sum);
      pos_next = 18'(pos_ff) + 18'(step_eff);
   end

   // Restoring division of |sum| by the channel count, one quotient bit a cycle.
   logic [4:0] dcnt_ff, dcnt_in;
   logic [18:0] dq_ff, dq_in;
   logic [18:0] trial;

   always_comb begin
      state_in = state_ff;
      fmt_in = fmt_ff; nch_in = nch_ff; step_in = step_ff; gain_in = gain_ff;
      prev_in = prev_ff; cur_in = cur_ff; pos_in = pos_ff; rem_in = rem_ff;
      dcnt_in = dcnt_ff; dq_in = dq_ff;
      v_in = v_ff; prod_in = prod_ff;
      iout_in = iout_ff; qout_in = qout_ff; last_in = last_ff; rv_in = rv_ff;
      cstart = 1'b0;
      trial = {rem_ff[17:0], dq_ff[18]} - {16'd0, n_eff};
      qabs = '0;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            stiq_pkg::REG_FORMAT: fmt_in = csr_data[1:0];
            stiq_pkg::REG_CHANNELS: nch_in = csr_data[2:0];
            stiq_pkg::REG_STEP: step_in = csr_data[16:0];
            stiq_pkg::REG_GAIN: gain_in = csr_data[15:0];
            default: ;
         endcase
      end
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         stiq_pkg::ST_IDLE: begin
            if (req_valid) state_in = stiq_pkg::ST_DIV;
         end
         stiq_pkg::ST_DIV: begin
            // restoring division of |sum| by n, one bit a cycle
            if (dcnt_ff == 5'd0) begin
               rem_in = '0; dq_in = asum; dcnt_in = 5'd1;
            end else begin
               if (!trial[18]) begin
                  rem_in = 19'(trial); dq_in = {dq_ff[17:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[17:0], dq_ff[18]}; dq_in = {dq_ff[17:0], 1'b0};
               end
               dcnt_in = dcnt_ff + 5'd1;
               if (dcnt_ff == 5'd19) begin
                  qabs = dq_in[15:0];
                  cur_in = sum[17] ? 16'(-qabs) : 16'(qabs);
                  dcnt_in = '0;
                  state_in = stiq_pkg::ST_MUL;
               end
            end
         end
         stiq_pkg::ST_MUL: begin
            // only the low 32 bits reach the phase, which wraps modulo one turn
            v_in = 32'(49'(signed'({prev_ff, 16'd0})) +
                       49'(17'(signed'(cur_ff)) - 17'(signed'(prev_ff))) *
                       49'(signed'({1'b0, pos_ff})));
            state_in = stiq_pkg::ST_ANGLE;
         end
         stiq_pkg::ST_ANGLE: begin
            prod_in = v_ff * {16'd0, gain_ff};
            state_in = stiq_pkg::ST_ROT;
         end
         stiq_pkg::ST_ROT: begin
            if (!rv_ff && dcnt_ff == 5'd0) begin
               cstart = 1'b1; dcnt_in = 5'd1;
            end
            if (cdone) begin
               iout_in = ci; qout_in = cq;
               last_in = pos_next[17:16] != 2'b00;
               state_in = stiq_pkg::ST_EMIT;
               dcnt_in = '0;
            end
         end
         stiq_pkg::ST_EMIT: begin
            if (!rv_ff) begin
               rv_in = 1'b1;
               if (last_ff) begin
                  pos_in = 17'(pos_next - 18'd65536);
                  prev_in = cur_ff;
                  state_in = stiq_pkg::ST_IDLE;
               end else begin
                  pos_in = pos_next[16:0];
                  state_in = stiq_pkg::ST_MUL;
               end
            end
         end
         default: state_in = stiq_pkg::ST_IDLE;
      endcase
   end

   stiq_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
      .clock(clock), .reset(reset), .start(cstart),
      .angle(prod_ff[31:32-ANGLE_BITS]),
      .done(cdone), .i_val(ci), .q_val(cq)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stiq_pkg::ST_IDLE;
         fmt_ff <= '0; nch_ff <= 3'd1; step_ff <= 17'd1024; gain_ff <= 16'd50;
         prev_ff <= '0; pos_ff <= '0; rv_ff <= 1'b0; dcnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         fmt_ff <= fmt_in; nch_ff <= nch_in; step_ff <= step_in; gain_ff <= gain_in;
         prev_ff <= prev_in; pos_ff <= pos_in; rv_ff <= rv_in; dcnt_ff <= dcnt_in;
      end
      cur_ff <= cur_in; rem_ff <= rem_in; dq_ff <= dq_in;
      v_ff <= v_in; prod_ff <= prod_in;
      iout_ff <= iout_in; qout_ff <= qout_in; last_ff <= last_in;
      if (req_valid && req_ready) begin
         ch_ff[0] <= req_chan0_raw; ch_ff[1] <= req_chan1_raw;
         ch_ff[2] <= req_chan2_raw; ch_ff[3] <= req_chan3_raw;
      end
   end

   assign req_ready = (state_ff == stiq_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rv_ff;
   assign rsp_i_out = iout_ff;
   assign rsp_q_out = qout_ff;
   assign rsp_last = last_ff;
endmodule
